// ===== rtl/ptst_pkg.sv =====
// Package for the pan/tilt servo tracker: limits, register indexes, constants.
// No dependencies.
package ptst_pkg;

	localparam logic [15:0] PAN_MIN  = 16'd11520;
	localparam logic [15:0] PAN_MAX  = 16'd34560;
	localparam logic [15:0] TILT_MIN = 16'd15360;
	localparam logic [15:0] TILT_MAX = 16'd20480;
	localparam logic [24:0] DEADBAND_SQ = 25'd167773;
	localparam logic [31:0] DER_MIN_DT  = 32'd50000;
	localparam logic [24:0] D_SCALE     = 25'd16000000;
	// integral increment: |err*dt| / 62500 = (|err*dt| >> 2) / 15625
	localparam logic [13:0] INC_DIV     = 14'd15625;
	localparam logic [27:0] INC_RECIP   = 28'd140737488;  // floor(2^41 / 15625)

	localparam int NREG = 8;
	localparam int AW   = 5;

	typedef enum logic [2:0] {
		R_PAN_KP  = 3'd0,
		R_PAN_KI  = 3'd1,
		R_PAN_KD  = 3'd2,
		R_TILT_KP = 3'd3,
		R_TILT_KI = 3'd4,
		R_TILT_KD = 3'd5,
		R_SCAN_PAN  = 3'd6,
		R_SCAN_TILT = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		K_SCAN  = 2'd0,
		K_FACE  = 2'd1,
		K_RESET = 2'd2,
		K_NONE  = 2'd3
	} kind_t;

endpackage

// ===== rtl/pan_tilt_servo_tracker.sv =====
// Pan/tilt servo tracker top level: APB registers, stream ports, PID sequencer.
// Depends on ptst_pkg.
//
// One request in, one result out. A scan tick, a controller reset or an unused kind
// passes S_PULSE1, S_PULSE2 and S_OUT; a scan tick on which pan reverses first passes
// S_TILT_STEP, which steps tilt; a face update in the deadband first passes S_FACE.
// One outside the deadband works both axes in turn; the derivative is off for dt of 50 ms
// or less, else each axis runs a 64-step restoring division by dt. The integral
// increment divides by a constant through a reciprocal product and at most a few
// compare-subtract steps; gain products go one by one through a shared 33x33
// multiplier. s_tready is low while a request is in work; a finished result waits
// in the output register, and the sequencer holds before it until that is free.
module pan_tilt_servo_tracker
	import ptst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // x_position[11:0], y_position[23:12], time_us[55:24]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // pan_angle[15:0], tilt_angle[30:16], pan_pulse_us[42:31],
	                              // tilt_pulse_us[54:43], zero[55]
	output logic        m_tuser   // in_deadband
);

	typedef enum logic [4:0] {
		S_IDLE, S_FACE, S_AX_START, S_INC_MUL, S_INC_EST, S_INC_QEST, S_INC_REM,
		S_INC_FIX, S_INC_SAT, S_P_MUL, S_I_MUL, S_D_MUL1, S_D_MUL2, S_D_DIV, S_D_ADD,
		S_ROUND, S_NEXT, S_TILT_STEP, S_PULSE1, S_PULSE2, S_OUT
	} state_t;

	state_t state_q;
	logic [15:0] kp_pan_q, ki_pan_q, kd_pan_q, kp_tilt_q, ki_tilt_q, kd_tilt_q;
	logic [14:0] step_pan_q, step_tilt_q;
	logic [15:0] pan_q, tilt_q;
	logic [31:0] last_ts_q;
	logic signed [31:0] psum_q, tsum_q;
	logic signed [12:0] plast_q, tlast_q;
	logic pan_up_q, tilt_down_q;

	logic [1:0]  kind_q;
	logic [11:0] x_q, y_q;
	logic [31:0] dt_q;
	logic        axis_q;      // 0 pan, 1 tilt
	logic signed [12:0] perr_q, terr_q;
	logic signed [63:0] acc_q;  // PID total
	logic signed [63:0] tmp_q;
	logic        dead_q;

	// shared multiplier
	logic signed [32:0] ma_q, mb_q;
	logic signed [65:0] mprod;
	logic [65:0] pmag;
	assign mprod = ma_q * mb_q;
	assign pmag = mprod[65] ? 66'(-mprod) : 66'(mprod);

	// shared restoring divider, unsigned magnitudes
	logic [63:0] dnum_q, drem_q;
	logic [31:0] dden_q;
	logic        dneg_q;
	logic [6:0]  dcnt_q;
	logic [64:0] dtrial;
	assign dtrial = {drem_q, dnum_q[63]} - {33'd0, dden_q};

	logic wr;
	assign wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[AW-1:2])
			R_PAN_KP:  prdata = {16'd0, kp_pan_q};
			R_PAN_KI:  prdata = {16'd0, ki_pan_q};
			R_PAN_KD:  prdata = {16'd0, kd_pan_q};
			R_TILT_KP: prdata = {16'd0, kp_tilt_q};
			R_TILT_KI: prdata = {16'd0, ki_tilt_q};
			R_TILT_KD: prdata = {16'd0, kd_tilt_q};
			R_SCAN_PAN:  prdata = {17'd0, step_pan_q};
			R_SCAN_TILT: prdata = {17'd0, step_tilt_q};
			default: prdata = 32'd0;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	// current axis views
	logic signed [12:0] err, lerr;
	logic signed [31:0] sum_cur;
	logic [15:0] kp, ki, kd;
	assign err = axis_q ? terr_q : perr_q;
	assign lerr = axis_q ? tlast_q : plast_q;
	assign sum_cur = axis_q ? tsum_q : psum_q;
	assign kp = axis_q ? kp_tilt_q : kp_pan_q;
	assign ki = axis_q ? ki_tilt_q : ki_pan_q;
	assign kd = axis_q ? kd_tilt_q : kd_pan_q;

	logic signed [12:0] ex, ey;
	logic signed [25:0] exsq, eysq;
	logic [24:0] rsq;
	assign ex = $signed({1'b0, x_q}) - 13'sd2048;
	assign ey = $signed({1'b0, y_q}) - 13'sd2048;
	assign exsq = 26'(ex) * 26'(ex);
	assign eysq = 26'(ey) * 26'(ey);
	assign rsq = 25'(exsq + eysq);

	// scan arithmetic
	logic at_pmax, at_pmin, pan_rev, tilt_rev_down, tilt_rev_up, t_dir;
	logic signed [17:0] pnext, tnext;
	logic [15:0] pclamp, tclamp;
	assign at_pmax = pan_q >= PAN_MAX && pan_up_q;
	assign at_pmin = pan_q <= PAN_MIN && !pan_up_q;
	assign pan_rev = at_pmax || at_pmin;
	assign tilt_rev_down = tilt_q >= TILT_MAX && tilt_down_q;
	assign tilt_rev_up = tilt_q <= TILT_MIN && !tilt_down_q;
	assign t_dir = tilt_rev_down ? 1'b0 : (tilt_rev_up ? 1'b1 : tilt_down_q);
	assign tnext = t_dir ? $signed({2'b0, tilt_q}) + $signed({3'b0, step_tilt_q})
	                     : $signed({2'b0, tilt_q}) - $signed({3'b0, step_tilt_q});
	assign tclamp = tnext < $signed({2'b0, TILT_MIN}) ? TILT_MIN :
	                tnext > $signed({2'b0, TILT_MAX}) ? TILT_MAX : tnext[15:0];
	logic p_dir;
	assign p_dir = pan_rev ? !pan_up_q : pan_up_q;
	assign pnext = p_dir ? $signed({2'b0, pan_q}) + $signed({3'b0, step_pan_q})
	                     : $signed({2'b0, pan_q}) - $signed({3'b0, step_pan_q});
	assign pclamp = pnext < $signed({2'b0, PAN_MIN}) ? PAN_MIN :
	                pnext > $signed({2'b0, PAN_MAX}) ? PAN_MAX : pnext[15:0];

	// divider result with sign
	logic signed [63:0] quo;
	assign quo = dneg_q ? -$signed(dnum_q) : $signed(dnum_q);

	// round and clamp of the PID total
	logic [63:0] amag;
	logic [47:0] rmag;
	logic signed [31:0] delta;
	assign amag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
	assign rmag = 48'((amag + 64'd32768) >> 16);
	always_comb begin
		if (rmag > 48'd1000000) delta = acc_q[63] ? -32'sd1000000 : 32'sd1000000;
		else delta = acc_q[63] ? -$signed(32'(rmag)) : $signed(32'(rmag));
	end
	logic signed [32:0] newang;
	logic [15:0] angcl;
	assign newang = $signed({17'd0, axis_q ? tilt_q : pan_q}) + 33'(delta);
	always_comb begin
		if (axis_q) angcl = newang < $signed({17'd0, TILT_MIN}) ? TILT_MIN :
		                    newang > $signed({17'd0, TILT_MAX}) ? TILT_MAX : newang[15:0];
		else angcl = newang < $signed({17'd0, PAN_MIN}) ? PAN_MIN :
		             newang > $signed({17'd0, PAN_MAX}) ? PAN_MAX : newang[15:0];
	end

	logic signed [64:0] sumx;
	assign sumx = 65'(sum_cur) + 65'(quo);

	// pulse = (ang*25 + 288)/576 + 500 via reciprocal: /576 = (>>6)/9
	logic [21:0] pnum;
	logic [15:0] pq6;
	logic [27:0] pm;
	logic [11:0] pq, pulse;
	assign pnum = 22'(tmp_q[15:0]) * 22'd25 + 22'd288;
	assign pq6 = pnum[21:6];
	assign pm = 28'(pq6) * 28'd7282;
	always_comb begin
		pq = 12'(pm >> 16);
		if (16'(pq6) - 16'(pq) * 16'd9 >= 16'd9) pq = pq + 12'd1;
		pulse = pq + 12'd500;
	end
	logic [11:0] ppulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kp_pan_q <= 16'd2560; ki_pan_q <= 16'd128; kd_pan_q <= 16'd1280;
			kp_tilt_q <= 16'd640; ki_tilt_q <= 16'd51; kd_tilt_q <= 16'd512;
			step_pan_q <= 15'd5120; step_tilt_q <= 15'd2560;
			pan_q <= 16'd23040; tilt_q <= 16'd17920;
			last_ts_q <= '0; psum_q <= '0; tsum_q <= '0;
			plast_q <= '0; tlast_q <= '0;
			pan_up_q <= 1'b0; tilt_down_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (wr) begin
				unique case (paddr[AW-1:2])
					R_PAN_KP:  kp_pan_q <= pwdata[15:0];
					R_PAN_KI:  ki_pan_q <= pwdata[15:0];
					R_PAN_KD:  kd_pan_q <= pwdata[15:0];
					R_TILT_KP: kp_tilt_q <= pwdata[15:0];
					R_TILT_KI: ki_tilt_q <= pwdata[15:0];
					R_TILT_KD: kd_tilt_q <= pwdata[15:0];
					R_SCAN_PAN:  step_pan_q <= pwdata[14:0];
					R_SCAN_TILT: step_tilt_q <= pwdata[14:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						kind_q <= s_tuser;
						x_q <= s_tdata[11:0];
						y_q <= s_tdata[23:12];
						dead_q <= 1'b0;
						unique case (s_tuser)
							K_SCAN: begin
								if (pan_rev) begin
									pan_up_q <= !pan_up_q;
									state_q <= S_TILT_STEP;
								end else state_q <= S_PULSE1;
							end
							K_FACE: begin
								dt_q <= s_tdata[55:24] - last_ts_q;
								last_ts_q <= s_tdata[55:24];
								state_q <= S_FACE;
							end
							K_RESET: begin
								last_ts_q <= s_tdata[55:24];
								psum_q <= '0; tsum_q <= '0;
								plast_q <= '0; tlast_q <= '0;
								state_q <= S_PULSE1;
							end
							default: state_q <= S_PULSE1;
						endcase
					end
				end
				S_TILT_STEP: begin
					tilt_down_q <= t_dir;
					tilt_q <= tclamp;
					state_q <= S_PULSE1;
				end
				S_FACE: begin
					if (rsq < DEADBAND_SQ) begin
						dead_q <= 1'b1;
						state_q <= S_PULSE1;
					end else begin
						perr_q <= -ex;
						terr_q <= ey;
						axis_q <= 1'b0;
						state_q <= S_AX_START;
					end
				end
				S_AX_START: begin
					ma_q <= 33'(err);
					mb_q <= $signed({1'b0, dt_q});
					state_q <= S_INC_MUL;
				end
				S_INC_MUL: begin
					dneg_q <= mprod[65];
					drem_q <= 64'(pmag >> 2);
					state_q <= S_INC_EST;
				end
				S_INC_EST: begin
					ma_q <= $signed({1'b0, drem_q[40:9]});
					mb_q <= $signed({5'd0, INC_RECIP});
					state_q <= S_INC_QEST;
				end
				S_INC_QEST: begin
					dnum_q <= {36'd0, mprod[59:32]};
					ma_q <= $signed({5'd0, mprod[59:32]});
					mb_q <= $signed({19'd0, INC_DIV});
					state_q <= S_INC_REM;
				end
				S_INC_REM: begin
					drem_q <= drem_q - 64'(mprod);
					state_q <= S_INC_FIX;
				end
				S_INC_FIX: begin
					if (drem_q >= {50'd0, INC_DIV}) begin
						drem_q <= drem_q - {50'd0, INC_DIV};
						dnum_q <= dnum_q + 64'd1;
					end else state_q <= S_INC_SAT;
				end
				S_D_DIV: begin
					if (dcnt_q == 7'd0) begin
						state_q <= S_D_ADD;
					end else begin
						dcnt_q <= dcnt_q - 7'd1;
						if (!dtrial[64]) begin
							drem_q <= dtrial[63:0];
							dnum_q <= {dnum_q[62:0], 1'b1};
						end else begin
							drem_q <= {drem_q[62:0], dnum_q[63]};
							dnum_q <= {dnum_q[62:0], 1'b0};
						end
					end
				end
				S_INC_SAT: begin
					logic signed [31:0] s;
					if (sumx > 65'sh0_7FFF_FFFF) s = 32'h7FFF_FFFF;
					else if (sumx < -65'sh0_8000_0000) s = 32'h8000_0000;
					else s = sumx[31:0];
					if (axis_q) tsum_q <= s; else psum_q <= s;
					ma_q <= 33'(s);
					mb_q <= $signed({17'd0, ki});
					state_q <= S_I_MUL;
				end
				S_I_MUL: begin
					acc_q <= 64'(mprod);
					ma_q <= 33'(err);
					mb_q <= $signed({17'd0, kp});
					state_q <= S_P_MUL;
				end
				S_P_MUL: begin
					acc_q <= acc_q + (64'(mprod) <<< 4);
					if (dt_q > DER_MIN_DT) begin
						ma_q <= 33'(err) - 33'(lerr);
						mb_q <= $signed({17'd0, kd});
						state_q <= S_D_MUL1;
					end else state_q <= S_ROUND;
				end
				S_D_MUL1: begin
					ma_q <= 33'(mprod);
					mb_q <= $signed({8'd0, D_SCALE});
					state_q <= S_D_MUL2;
				end
				S_D_MUL2: begin
					dneg_q <= mprod[65];
					dnum_q <= mprod[65] ? 64'(-mprod) : 64'(mprod);
					drem_q <= '0;
					dden_q <= dt_q;
					dcnt_q <= 7'd64;
					state_q <= S_D_DIV;
				end
				S_D_ADD: begin
					acc_q <= acc_q + quo;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					if (axis_q) tilt_q <= angcl; else pan_q <= angcl;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (axis_q) begin
						plast_q <= perr_q;
						tlast_q <= terr_q;
						state_q <= S_PULSE1;
					end else begin
						axis_q <= 1'b1;
						state_q <= S_AX_START;
					end
				end
				S_PULSE1: begin
					if (kind_q == K_SCAN) pan_q <= pclamp;
					tmp_q <= 64'(kind_q == K_SCAN ? pclamp : pan_q);
					state_q <= S_PULSE2;
				end
				S_PULSE2: begin
					ppulse_q <= pulse;
					tmp_q <= 64'(tilt_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid) begin
						m_tdata <= {1'b0, pulse, ppulse_q, tilt_q[14:0], pan_q};
						m_tuser <= dead_q;
						m_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		pan_q >= PAN_MIN && pan_q <= PAN_MAX) else $error("pan out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		tilt_q >= TILT_MIN && tilt_q <= TILT_MAX) else $error("tilt out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !m_tvalid) |=> m_tvalid) else $error("result lost");

endmodule
